/* rtl/bmm_pkg.sv */
package bmm_pkg;

    localparam int MAX_DIM_DEFAULT = 32;

    localparam int VALUE_W   = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 40;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COUNT = 2'd3;

    typedef enum logic [1:0] {
        ST_PRODUCT = 2'd0,
        ST_A_EARLY = 2'd1,
        ST_B_LATE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clear;
        logic    b_wr;
        logic    a_ld;
        logic    mac;
        logic    emit;
        logic    end_row;
        logic    end_mat;
        logic    end_bat;
        logic    reject;
        t_status status;
    } t_cmd;

endpackage

/* rtl/bmm_datapath.sv */
module bmm_datapath #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bmm_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     i_wr_addr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     i_rd_addr,
    input  logic [$clog2(MAX_DIM)-1:0]             i_j,
    input  logic signed [bmm_pkg::VALUE_W-1:0]     i_value,
    input  logic                                   i_out_stall,
    output logic                                   o_out_free,
    output logic                                   o_out_valid,
    output logic signed [bmm_pkg::ACC_W-1:0]       o_product,
    output logic                                   o_last_in_row,
    output logic                                   o_last_in_matrix,
    output logic                                   o_last_of_batch,
    output logic [1:0]                             o_status
);
    import bmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int JW    = $clog2(MAX_DIM);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;
    logic signed [VALUE_W-1:0] r_a_val;
    logic                      r_v1;
    logic [JW-1:0]             r_j1;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_v2;
    logic [JW-1:0]             r_j2;
    logic signed [ACC_W-1:0]   r_acc [MAX_DIM];

    logic                      r_out_valid;
    logic signed [ACC_W-1:0]   r_out_product;
    logic                      r_out_row;
    logic                      r_out_mat;
    logic                      r_out_bat;
    t_status                   r_out_status;

    logic [JW-1:0]             w_acc_idx;
    logic signed [ACC_W-1:0]   w_acc_rd;
    logic                      w_out_free;

    // B store: one write port for loading, one registered read port for the MAC lane.
    always_ff @(posedge i_clk) begin
        if (i_cmd.b_wr) begin
            r_mem[i_wr_addr] <= i_value;
        end
        if (i_cmd.mac) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_cmd.a_ld) begin
            r_a_val <= i_value;
        end
        r_j1   <= i_j;
        r_prod <= r_a_val * r_rd_data;
        r_j2   <= r_j1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac;
            r_v2 <= r_v1;
        end
    end

    assign w_acc_idx = i_cmd.emit ? i_j : r_j2;
    assign w_acc_rd  = r_acc[w_acc_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < MAX_DIM; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_v2) begin
            r_acc[w_acc_idx] <= w_acc_rd + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end else if (i_cmd.emit) begin
            r_acc[w_acc_idx] <= '0;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.reject) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_product <= w_acc_rd;
            r_out_row     <= i_cmd.end_row;
            r_out_mat     <= i_cmd.end_mat;
            r_out_bat     <= i_cmd.end_bat;
            r_out_status  <= ST_PRODUCT;
        end else if (i_cmd.reject) begin
            r_out_product <= '0;
            r_out_row     <= 1'b0;
            r_out_mat     <= 1'b0;
            r_out_bat     <= 1'b0;
            r_out_status  <= i_cmd.status;
        end
    end

    assign o_out_free       = w_out_free;
    assign o_out_valid      = r_out_valid;
    assign o_product        = r_out_product;
    assign o_last_in_row    = r_out_row;
    assign o_last_in_matrix = r_out_mat;
    assign o_last_of_batch  = r_out_bat;
    assign o_status         = r_out_status;

endmodule

/* rtl/bmm_ctrl.sv */
module bmm_ctrl #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bmm_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_mode,
    input  logic                                   i_out_free,
    output bmm_pkg::t_cmd                          o_cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     o_wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     o_rd_addr,
    output logic [$clog2(MAX_DIM)-1:0]             o_j
);
    import bmm_pkg::*;

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int JW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int FW = 2 * DW;

    t_state        r_state, n_state;
    logic [15:0]   r_rows_a;
    logic [5:0]    r_inner;
    logic [5:0]    r_cols;
    logic [15:0]   r_mcount;
    logic [FW-1:0] r_fill, n_fill;
    logic [DW-1:0] r_a_col, n_a_col;
    logic [AW-1:0] r_base, n_base;
    logic [JW-1:0] r_j, n_j;
    logic [15:0]   r_c_row, n_c_row;
    logic [15:0]   r_mat, n_mat;

    logic [DW-1:0] w_inner_eff;
    logic [DW-1:0] w_cols_eff;
    logic [DW-1:0] w_cols_m1;
    logic [15:0]   w_rows_eff;
    logic [15:0]   w_mats_eff;
    logic [FW-1:0] w_b_total;
    logic          w_b_full;
    logic          w_j_last;
    logic          w_a_last;
    logic          w_last_row;
    logic          w_last_mat;
    t_cmd          w_cmd;
    logic          w_stall;

    // Zero acts as one; a dimension beyond the array size acts as the array size.
    assign w_inner_eff = (r_inner == 6'd0) ? DW'(1) :
                         (int'(r_inner) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_inner);
    assign w_cols_eff  = (r_cols == 6'd0) ? DW'(1) :
                         (int'(r_cols) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_cols);
    assign w_cols_m1   = w_cols_eff - DW'(1);
    assign w_rows_eff  = (r_rows_a == 16'd0) ? 16'd1 : r_rows_a;
    assign w_mats_eff  = (r_mcount == 16'd0) ? 16'd1 : r_mcount;
    assign w_b_total   = FW'(w_inner_eff) * FW'(w_cols_eff);
    assign w_b_full    = r_fill >= w_b_total;
    assign w_j_last    = DW'(r_j) == w_cols_m1;
    assign w_a_last    = (r_a_col + DW'(1)) == w_inner_eff;
    assign w_last_row  = ({1'b0, r_c_row} + 17'd1) >= {1'b0, w_rows_eff};
    assign w_last_mat  = w_last_row && (({1'b0, r_mat} + 17'd1) >= {1'b0, w_mats_eff});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= 16'd1;
            r_inner  <= 6'd1;
            r_cols   <= 6'd1;
            r_mcount <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROWS_A:       r_rows_a <= i_cfg_data;
                REG_INNER_SIZE:   r_inner  <= i_cfg_data[5:0];
                REG_COLS_B:       r_cols   <= i_cfg_data[5:0];
                REG_MATRIX_COUNT: r_mcount <= i_cfg_data;
                default:          r_rows_a <= r_rows_a;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_a_col <= '0;
            r_base  <= '0;
            r_j     <= '0;
            r_c_row <= '0;
            r_mat   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_a_col <= n_a_col;
            r_base  <= n_base;
            r_j     <= n_j;
            r_c_row <= n_c_row;
            r_mat   <= n_mat;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_a_col = r_a_col;
        n_base  = r_base;
        n_j     = r_j;
        n_c_row = r_c_row;
        n_mat   = r_mat;
        w_cmd   = '0;
        w_stall = 1'b1;

        if (i_cfg_we) begin
            // Any register write aborts the batch in progress.
            w_cmd.clear = 1'b1;
            n_state     = S_IDLE;
            n_fill      = '0;
            n_a_col     = '0;
            n_base      = '0;
            n_j         = '0;
            n_c_row     = '0;
            n_mat       = '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    w_stall = !i_out_free;
                    if (i_in_valid && i_out_free) begin
                        if (!i_mode) begin
                            if (w_b_full) begin
                                w_cmd.reject = 1'b1;
                                w_cmd.status = ST_B_LATE;
                            end else begin
                                w_cmd.b_wr = 1'b1;
                                n_fill     = r_fill + FW'(1);
                            end
                        end else begin
                            if (!w_b_full) begin
                                w_cmd.reject = 1'b1;
                                w_cmd.status = ST_A_EARLY;
                            end else begin
                                w_cmd.a_ld = 1'b1;
                                n_j        = '0;
                                n_state    = S_MAC;
                            end
                        end
                    end
                end
                S_MAC: begin
                    w_cmd.mac = 1'b1;
                    n_j       = r_j + JW'(1);
                    if (w_j_last) begin
                        n_j = '0;
                        if (w_a_last) begin
                            n_state = S_DRAIN1;
                        end else begin
                            n_a_col = r_a_col + DW'(1);
                            n_base  = r_base + AW'(w_cols_eff);
                            n_state = S_IDLE;
                        end
                    end
                end
                S_DRAIN1: begin
                    n_state = S_DRAIN2;
                end
                S_DRAIN2: begin
                    n_state = S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        w_cmd.emit    = 1'b1;
                        w_cmd.end_row = w_j_last;
                        w_cmd.end_mat = w_j_last && w_last_row;
                        w_cmd.end_bat = w_j_last && w_last_mat;
                        n_j           = r_j + JW'(1);
                        if (w_j_last) begin
                            n_j     = '0;
                            n_a_col = '0;
                            n_base  = '0;
                            n_state = S_IDLE;
                            n_c_row = r_c_row + 16'd1;
                            if (w_last_row) begin
                                n_c_row = '0;
                                n_fill  = '0;
                                n_mat   = w_last_mat ? 16'd0 : r_mat + 16'd1;
                            end
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = w_stall;
    assign o_wr_addr  = r_fill[AW-1:0];
    assign o_rd_addr  = r_base + AW'(r_j);
    assign o_j        = r_j;

endmodule

/* rtl/batched_matrix_multiply.sv */
// Batched matrix multiplier, C = A * B, one matrix pair at a time. For each pair, send the
// inner_size x cols_b elements of B row-major with mode 0, then the elements of A row-major
// with mode 1; after the last A element of each row the block returns that row of C as
// cols_b transactions, flagged at the end of the row, the matrix and the batch. Values are
// signed Q8.8 and every C element is the exact signed Q24.16 sum in 40 bits. An A element
// that arrives before B is complete, or a B element after it is complete, is answered by one
// transaction with product 0, no flags and a nonzero status, and changes nothing. A register
// value of 0 acts as 1, and inner_size or cols_b above MAX_DIM acts as MAX_DIM. Any
// configuration write aborts the batch and requires B to be loaded again; write registers
// only while the block is idle. A B element is simply stored. An A element holds the input
// side while a single multiply-accumulate lane walks the columns of the matching B row, one
// read of the B memory per cycle. An A element that completes a row then lets the lane's
// pipeline drain through S_DRAIN1 and S_DRAIN2 and returns one C element per cycle, more
// slowly while the output side stalls. The input side also stalls while a finished output
// transaction waits to be taken and the output register cannot be refilled.
module batched_matrix_multiply #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bmm_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_mode,
    input  logic signed [bmm_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [bmm_pkg::ACC_W-1:0]   o_product,
    output logic                               o_last_in_row,
    output logic                               o_last_in_matrix,
    output logic                               o_last_of_batch,
    output logic [1:0]                         o_status
);
    import bmm_pkg::*;

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int JW = $clog2(MAX_DIM);

    // Command bundle and addressing from the controller to the datapath.
    t_cmd          w_cmd;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [JW-1:0] w_j;
    // The output register can take a new transaction in this cycle.
    logic          w_out_free;

    bmm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_out_free  (w_out_free),
        .o_cmd       (w_cmd),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr   (w_rd_addr),
        .o_j         (w_j)
    );

    bmm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_wr_addr        (w_wr_addr),
        .i_rd_addr        (w_rd_addr),
        .i_j              (w_j),
        .i_value          (i_value),
        .i_out_stall      (i_out_stall),
        .o_out_free       (w_out_free),
        .o_out_valid      (o_out_valid),
        .o_product        (o_product),
        .o_last_in_row    (o_last_in_row),
        .o_last_in_matrix (o_last_in_matrix),
        .o_last_of_batch  (o_last_of_batch),
        .o_status         (o_status)
    );

endmodule

/* tb/sv/bmm_result_checker.sv */
module bmm_result_checker #(
    parameter int   MAX_DIM = bmm_pkg::MAX_DIM_DEFAULT,
    parameter logic MODE_B  = 1'b0,
    parameter logic MODE_A  = 1'b1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bmm_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic                                 i_mode,
    input  logic signed [bmm_pkg::VALUE_W-1:0]   i_value,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [bmm_pkg::ACC_W-1:0]     i_product,
    input  logic                                 i_last_in_row,
    input  logic                                 i_last_in_matrix,
    input  logic                                 i_last_of_batch,
    input  logic [1:0]                           i_status,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bmm_pkg::*;

    typedef struct {
        logic signed [ACC_W-1:0] product;
        logic                    last_row;
        logic                    last_mat;
        logic                    last_batch;
        t_status                 status;
    } t_c_elem;

    t_c_elem c_due[$];

    logic [15:0]               rows_reg;
    logic [5:0]                inner_reg;
    logic [5:0]                cols_reg;
    logic [15:0]               mats_reg;
    logic signed [VALUE_W-1:0] b_vals [MAX_DIM*MAX_DIM];
    logic signed [ACC_W-1:0]   col_sums [MAX_DIM];
    int unsigned               b_filled;
    int unsigned               a_col;
    int unsigned               c_row;
    int unsigned               mat_idx;
    int                        fails = 0;

    // A size of zero means one; a matrix dimension is capped at MAX_DIM.
    function automatic int unsigned dim_of(logic [5:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned count_of(logic [15:0] v);
        return (v == 0) ? 1 : v;
    endfunction

    function void restart_batch();
        for (int j = 0; j < MAX_DIM; j++) col_sums[j] = '0;
        b_filled = 0;
        a_col    = 0;
        c_row    = 0;
        mat_idx  = 0;
    endfunction

    function void reject(t_status st);
        t_c_elem e;
        e.product    = '0;
        e.last_row   = 1'b0;
        e.last_mat   = 1'b0;
        e.last_batch = 1'b0;
        e.status     = st;
        c_due.insert(c_due.size(), e);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_ROWS_A:       rows_reg  = data;
            REG_INNER_SIZE:   inner_reg = data[5:0];
            REG_COLS_B:       cols_reg  = data[5:0];
            REG_MATRIX_COUNT: mats_reg  = data;
            default: ;
        endcase
        restart_batch();
    endfunction

    // Works out the C elements that one accepted input transaction produces.
    function void multiply_step(logic mode, logic signed [VALUE_W-1:0] value);
        t_c_elem            e;
        int unsigned        inner;
        int unsigned        cols;
        int unsigned        rows;
        int unsigned        mats;
        logic signed [31:0] prod;
        logic               last_row;
        logic               last_mat;
        inner = dim_of(inner_reg);
        cols  = dim_of(cols_reg);
        rows  = count_of(rows_reg);
        mats  = count_of(mats_reg);
        if (mode == MODE_B) begin
            if (b_filled >= inner * cols) begin
                reject(ST_B_LATE);
                return;
            end
            b_vals[b_filled] = value;
            b_filled++;
            return;
        end
        if (b_filled < inner * cols) begin
            reject(ST_A_EARLY);
            return;
        end
        for (int j = 0; j < cols; j++) begin
            prod        = value * b_vals[a_col * cols + j];
            col_sums[j] = col_sums[j] + prod;
        end
        a_col++;
        if (a_col < inner) return;
        last_row = (c_row + 1 >= rows);
        last_mat = last_row && (mat_idx + 1 >= mats);
        for (int j = 0; j < cols; j++) begin
            e.product    = col_sums[j];
            e.last_row   = (j == cols - 1);
            e.last_mat   = e.last_row && last_row;
            e.last_batch = e.last_row && last_mat;
            e.status     = ST_PRODUCT;
            c_due.insert(c_due.size(), e);
            col_sums[j] = '0;
        end
        a_col = 0;
        c_row++;
        if (last_row) begin
            c_row    = 0;
            b_filled = 0;
            mat_idx  = last_mat ? 0 : mat_idx + 1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_c_elem want;
        if (!i_rst_n) begin
            rows_reg  = 16'd1;
            inner_reg = 6'd1;
            cols_reg  = 6'd1;
            mats_reg  = 16'd1;
            restart_batch();
            c_due.delete();
        end else begin
            // The output is checked first: a result can never stem from the
            // input transaction accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (c_due.size() == 0) begin
                    $display("%0t: unexpected result, product %0d status %0d",
                             $time, i_product, i_status);
                    fails++;
                end else begin
                    want = c_due.pop_front();
                    if (i_product !== want.product) begin
                        $display("%0t: product mismatch, expected %0d, actual %0d",
                                 $time, want.product, i_product);
                        fails++;
                    end
                    if (i_last_in_row !== want.last_row) begin
                        $display("%0t: last_in_row mismatch, expected %0b, actual %0b",
                                 $time, want.last_row, i_last_in_row);
                        fails++;
                    end
                    if (i_last_in_matrix !== want.last_mat) begin
                        $display("%0t: last_in_matrix mismatch, expected %0b, actual %0b",
                                 $time, want.last_mat, i_last_in_matrix);
                        fails++;
                    end
                    if (i_last_of_batch !== want.last_batch) begin
                        $display("%0t: last_of_batch mismatch, expected %0b, actual %0b",
                                 $time, want.last_batch, i_last_of_batch);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) multiply_step(i_mode, i_value);
        end
        o_pending    <= c_due.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/batched_matrix_multiply_tb.sv */
module batched_matrix_multiply_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmm_pkg::*;

    localparam int   MAX_DIM      = MAX_DIM_DEFAULT;
    localparam logic MODE_B       = 1'b0;
    localparam logic MODE_A       = 1'b1;
    // Random input transactions after the directed part.
    localparam int   RANDOM_ITEMS = 340;
    // Idling stops for the last stretch of the random part.
    localparam int   QUIET_TAIL   = 40;
    // The long output hold-off starts once this many random items went in.
    localparam int   PRESSURE_AT  = 120;
    localparam int   HOLD_CYCLES  = 400;
    // An A element walks up to MAX_DIM columns and a row drains through a
    // short pipeline, so this many cycles covers any work still in flight.
    localparam int   DRAIN_CYCLES = 3 * MAX_DIM + 16;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = REG_ROWS_A;
    logic [CFG_W-1:0]          i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic                      i_mode      = MODE_B;
    logic signed [VALUE_W-1:0] i_value     = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [ACC_W-1:0]   o_product;
    logic                      o_last_in_row;
    logic                      o_last_in_matrix;
    logic                      o_last_of_batch;
    logic [1:0]                o_status;

    int                        fail_count;
    int                        results_due;

    // Sender state; quiet and hold_req are shared with the receiver process.
    bit                        quiet         = 1'b0;
    bit                        hold_req      = 1'b0;
    bit                        pressure_done = 1'b0;
    int unsigned               sent          = 0;
    int unsigned               random_base   = 0;

    batched_matrix_multiply #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_product       (o_product),
        .o_last_in_row   (o_last_in_row),
        .o_last_in_matrix(o_last_in_matrix),
        .o_last_of_batch (o_last_of_batch),
        .o_status        (o_status)
    );

    // The checker watches both channels and the register port, predicts every
    // C element and compares each output transaction against it.
    bmm_result_checker #(
        .MAX_DIM(MAX_DIM),
        .MODE_B (MODE_B),
        .MODE_A (MODE_A)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_product       (o_product),
        .i_last_in_row   (o_last_in_row),
        .i_last_in_matrix(o_last_in_matrix),
        .i_last_of_batch (o_last_of_batch),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The whole run, even the slowest correct one, ends far before this.
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Element values lean toward the Q8.8 extremes and zero now and then.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Mostly small dimensions, sometimes zero and sometimes at or past MAX_DIM.
    function automatic logic [5:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return 6'd0;
            1:       return 6'($urandom_range(MAX_DIM, 63));
            default: return 6'($urandom_range(1, 5));
        endcase
    endfunction

    // Offers one input transaction and returns at the edge where it is taken.
    // A random gap with valid low may come first; the payload holds steady
    // while the block stalls.
    task automatic send_elem(input logic mode, input logic signed [VALUE_W-1:0] val);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        if (random_base != 0 && sent >= random_base + RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
    endtask

    // Waits until every predicted result has come out and then lets the block
    // finish any multiply-accumulate work that produces no result.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Programs one setting and streams well-formed matrix pairs through it.
    // With noise on, stray A elements fall into the B load, stray B elements
    // into the A stream, a batch may run one matrix past its end to wrap, and
    // a batch may be cut short so that the next register write aborts it.
    task automatic run_batch(input logic [15:0] rows, input logic [5:0] inner,
                             input logic [5:0] cols, input logic [15:0] mats,
                             input bit noisy);
        int unsigned ni;
        int unsigned nc;
        int unsigned nr;
        int unsigned nm;
        int unsigned rows_run;
        int unsigned mats_run;
        int unsigned a_left;
        settle();
        write_reg(REG_ROWS_A, CFG_W'(rows));
        write_reg(REG_INNER_SIZE, CFG_W'(inner));
        write_reg(REG_COLS_B, CFG_W'(cols));
        write_reg(REG_MATRIX_COUNT, CFG_W'(mats));
        i_cfg_we <= 1'b0;
        ni = (inner == 0) ? 1 : (inner > MAX_DIM) ? MAX_DIM : inner;
        nc = (cols == 0) ? 1 : (cols > MAX_DIM) ? MAX_DIM : cols;
        nr = (rows == 0) ? 1 : rows;
        nm = (mats == 0) ? 1 : mats;
        // Huge row or matrix counts are only started, never finished.
        rows_run = (nr > 3) ? 2 : nr;
        mats_run = (nr > 3 || nm > 3) ? 1 : nm + ((noisy && $urandom_range(0, 3) == 0) ? 1 : 0);
        a_left = (noisy && $urandom_range(0, 7) == 0) ?
                 $urandom_range(0, rows_run * ni * mats_run - 1) : 32'hFFFF_FFFF;
        for (int m = 0; m < mats_run; m++) begin
            for (int k = 0; k < ni * nc; k++) begin
                if (noisy && $urandom_range(0, 11) == 0) send_elem(MODE_A, pick_value());
                send_elem(MODE_B, pick_value());
            end
            if (noisy && $urandom_range(0, 5) == 0) send_elem(MODE_B, pick_value());
            for (int k = 0; k < rows_run * ni; k++) begin
                if (a_left == 0) return;
                a_left--;
                // Once, the receiver holds off long enough for the block to
                // fill up and stall the A stream behind it.
                if (!pressure_done && sent >= random_base + PRESSURE_AT && random_base != 0) begin
                    hold_req      = 1'b1;
                    pressure_done = 1'b1;
                end
                send_elem(MODE_A, pick_value());
                // A stray B after the last A of a matrix would start the next
                // B load, so it only lands inside the stream.
                if (noisy && k != rows_run * ni - 1 && $urandom_range(0, 19) == 0)
                    send_elem(MODE_B, pick_value());
            end
        end
    endtask

    // Receiver: random stall bursts, the one long hold-off, and no stalls at
    // all once the run is in its quiet tail.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int unsigned phase;
        logic [15:0] rows;
        logic [5:0]  inner;
        logic [5:0]  cols;
        logic [15:0] mats;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset setting, a 1x1 by 1x1 product. An A
        // element before B, then B, then a B element with B already complete.
        send_elem(MODE_A, 16'sh0100);
        send_elem(MODE_B, 16'sh7FFF);
        send_elem(MODE_B, 16'sh8000);
        // Largest negative product; it closes the batch, which wraps.
        send_elem(MODE_A, 16'sh8000);
        // B is empty again after the wrap, so this A is turned away.
        send_elem(MODE_A, 16'sh7FFF);
        // Most negative times itself gives the largest positive product.
        send_elem(MODE_B, 16'sh8000);
        send_elem(MODE_A, 16'sh8000);
        send_elem(MODE_B, 16'sh0000);
        send_elem(MODE_A, 16'shFFFF);
        // Two 1x2 by 2x2 pairs show the row, matrix and batch flags apart.
        run_batch(16'd1, 6'd2, 6'd2, 16'd2, 1'b0);

        // Random part. The first settings hit the register extremes: zero
        // sizes and oversized columns, then all-ones counts with an oversized
        // inner size, a batch that the next write aborts.
        random_base = sent;
        phase = 0;
        while (sent < random_base + RANDOM_ITEMS) begin
            case (phase)
                0: run_batch(16'd0, 6'd0, 6'd63, 16'd0, 1'b1);
                1: run_batch(16'hFFFF, 6'd63, 6'd0, 16'hFFFF, 1'b1);
                default: begin
                    rows  = 16'($urandom_range(0, 3));
                    inner = pick_dim();
                    cols  = pick_dim();
                    mats  = 16'($urandom_range(0, 3));
                    // Keep large shapes short so that most time goes to
                    // many small matrices.
                    if (inner >= MAX_DIM && cols >= MAX_DIM) cols = 6'($urandom_range(1, 3));
                    if (inner >= MAX_DIM || cols >= MAX_DIM) begin
                        rows = 16'($urandom_range(0, 1));
                        mats = 16'd1;
                    end
                    run_batch(rows, inner, cols, mats, 1'b1);
                end
            endcase
            phase++;
        end

        quiet = 1'b1;
        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
